### rtl/skc_pkg.sv
// Shared constants, types and round functions for the SKINNY-128 block.
package skc_pkg;

   localparam int unsigned NUM_CSR = 8;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned MAX_ROUNDS = 56;
   localparam int unsigned ROUND_W = 6;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY0_LO = 3'd0,
      CSR_KEY0_HI = 3'd1,
      CSR_KEY1_LO = 3'd2,
      CSR_KEY1_HI = 3'd3,
      CSR_KEY2_LO = 3'd4,
      CSR_KEY2_HI = 3'd5,
      CSR_KEY_WORDS = 3'd6,
      CSR_TWEAKED = 3'd7
   } csr_idx_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;      // latch block, tweakeys, counts
      logic fwd_key;   // advance tweakey schedule one round (no state change)
      logic round;     // apply one cipher round
      logic done;      // present result
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic [ROUND_W-1:0] rounds;
      logic               decrypt;
   } dp_sts_type;

   function automatic logic [31:0] sb_fwd(input logic [31:0] xi);
      logic [31:0] x, y;
      x = xi;
      x = x ^ ((~((x >> 2) | (x >> 3))) & 32'h11111111);
      y = (~((x << 5) | (x << 1))) & 32'h20202020;
      x = x ^ (((~((x << 5) | (x << 4))) & 32'h40404040) ^ y);
      y = (~((x << 2) | (x << 1))) & 32'h80808080;
      x = x ^ (((~((x >> 2) | (x << 1))) & 32'h02020202) ^ y);
      y = (~((x >> 5) | (x << 1))) & 32'h04040404;
      x = x ^ (((~((x >> 1) | (x >> 2))) & 32'h08080808) ^ y);
      return ((x & 32'h08080808) << 1) | ((x & 32'h32323232) << 2) |
             ((x & 32'h01010101) << 5) | ((x & 32'h80808080) >> 6) |
             ((x & 32'h40404040) >> 4) | ((x & 32'h04040404) >> 2);
   endfunction

   function automatic logic [31:0] sb_inv(input logic [31:0] xi);
      logic [31:0] x, y;
      x = xi;
      y = (~((x >> 1) | (x >> 3))) & 32'h01010101;
      x = x ^ (((~((x >> 2) | (x >> 3))) & 32'h10101010) ^ y);
      y = (~((x >> 6) | (x >> 1))) & 32'h02020202;
      x = x ^ (((~((x >> 1) | (x >> 2))) & 32'h08080808) ^ y);
      y = (~((x << 2) | (x << 1))) & 32'h80808080;
      x = x ^ (((~((x >> 1) | (x << 2))) & 32'h04040404) ^ y);
      y = (~((x << 5) | (x << 1))) & 32'h20202020;
      x = x ^ (((~((x << 4) | (x << 5))) & 32'h40404040) ^ y);
      return ((x & 32'h01010101) << 2) | ((x & 32'h04040404) << 4) |
             ((x & 32'h02020202) << 6) | ((x & 32'h20202020) >> 5) |
             ((x & 32'hC8C8C8C8) >> 2) | ((x & 32'h10101010) >> 1);
   endfunction

   function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned c);
      return (x << c) | (x >> (32 - c));
   endfunction

   function automatic logic [31:0] lfsr2(input logic [31:0] x);
      return ((x << 1) & 32'hFEFEFEFE) ^ (((x >> 7) ^ (x >> 5)) & 32'h01010101);
   endfunction

   function automatic logic [31:0] lfsr3(input logic [31:0] x);
      return ((x >> 1) & 32'h7F7F7F7F) ^ (((x << 7) ^ (x << 1)) & 32'h80808080);
   endfunction

   function automatic logic [31:0] lfsr2_inv(input logic [31:0] x);
      return ((x >> 1) & 32'h7F7F7F7F) ^ (((x << 7) ^ (x << 1)) & 32'h80808080);
   endfunction

   function automatic logic [31:0] lfsr3_inv(input logic [31:0] x);
      return ((x << 1) & 32'hFEFEFEFE) ^ (((x >> 7) ^ (x >> 5)) & 32'h01010101);
   endfunction

   // Forward cell permutation of one tweakey word
   function automatic logic [127:0] tk_perm(input logic [127:0] t);
      logic [31:0] a, b, t0, t1;
      a = t[95:64];
      b = t[127:96];
      b = {b[15:0], b[31:16]};
      t0 = ((a >> 8) & 32'h000000FF) | ((a << 16) & 32'h00FF0000) | (b & 32'hFF00FF00);
      t1 = ((a >> 16) & 32'h000000FF) | (a & 32'hFF000000) |
           ((b << 8) & 32'h0000FF00) | (b & 32'h00FF0000);
      return {t[63:32], t[31:0], t1, t0};
   endfunction

   // Inverse cell permutation (byte-level inverse of tk_perm)
   function automatic logic [127:0] tk_perm_inv(input logic [127:0] t);
      logic [127:0] p, r;
      logic [3:0]   src;
      p = tk_perm(128'h0F0E0D0C0B0A09080706050403020100);
      r = '0;
      for (int i = 0; i < 16; i++) begin
         src = p[i*8 +: 4];
         r[src*8 +: 8] = t[i*8 +: 8];
      end
      return r;
   endfunction

   function automatic logic [5:0] rc_next(input logic [5:0] rc);
      return {rc[4:0], 1'b0} ^ {5'd0, rc[5] ^ rc[4] ^ 1'b1};
   endfunction

   function automatic logic [5:0] rc_prev(input logic [5:0] rc);
      return {rc[0] ^ rc[5] ^ 1'b1, rc[5:1]};
   endfunction

endpackage

### rtl/skc_datapath.sv
// SKINNY-128 datapath: state register, tweakey registers, round function.
module skc_datapath (
   input  logic                    clock,
   input  skc_pkg::dp_cmd_type     cmd,
   output skc_pkg::dp_sts_type     sts,
   input  logic                    req_kind,
   input  logic [63:0]             req_block_lo,
   input  logic [63:0]             req_block_hi,
   input  logic [63:0]             req_tweak_lo,
   input  logic [63:0]             req_tweak_hi,
   input  logic [383:0]            key_words_in,
   input  logic [1:0]              key_words,
   input  logic                    tweaked,
   output logic [63:0]             rsp_result_lo,
   output logic [63:0]             rsp_result_hi
);
   import skc_pkg::*;

   logic [127:0] st_ff, st_in;
   logic [127:0] tk1_ff, tk2_ff, tk3_ff, tk1_in, tk2_in, tk3_in;
   logic [5:0]   rc_ff, rc_in;
   logic         dec_ff, tw_ff, use2_ff, use3_ff;
   logic [ROUND_W-1:0] rounds_ff;
   logic [1:0]   words;
   logic [31:0]  k0, k1;
   logic [5:0]   rc_use;
   logic [31:0]  s0, s1, s2, s3, t;

   assign words = (key_words == 2'd0) ? 2'd1 : key_words;

   // Round key from current tweakeys and the next constant
   always_comb begin
      rc_use = rc_next(rc_ff);
      k0 = tk1_ff[31:0] ^ (use2_ff ? tk2_ff[31:0] : 32'd0) ^
           (use3_ff ? tk3_ff[31:0] : 32'd0) ^ {28'd0, rc_use[3:0]} ^
           (tw_ff ? 32'h00020000 : 32'd0);
      k1 = tk1_ff[63:32] ^ (use2_ff ? tk2_ff[63:32] : 32'd0) ^
           (use3_ff ? tk3_ff[63:32] : 32'd0) ^ {30'd0, rc_use[5:4]};
   end

   // Round datapath and tweakey schedule
   always_comb begin
      st_in = st_ff; tk1_in = tk1_ff; tk2_in = tk2_ff; tk3_in = tk3_ff; rc_in = rc_ff;
      s0 = '0; s1 = '0; s2 = '0; s3 = '0; t = '0;
      if (cmd.load) begin
         st_in = {req_block_hi, req_block_lo};
         rc_in = 6'd0;
         if (tweaked) begin
            tk1_in = {req_tweak_hi, req_tweak_lo};
            tk2_in = key_words_in[127:0];
            tk3_in = key_words_in[255:128];
         end else begin
            tk1_in = key_words_in[127:0];
            tk2_in = key_words_in[255:128];
            tk3_in = key_words_in[383:256];
         end
      end else if (cmd.fwd_key) begin
         // run schedule forward to the last round's tweakey
         tk1_in = tk_perm(tk1_ff);
         tk2_in = tk_perm(tk2_ff);
         tk2_in[63:0] = {lfsr2(tk2_in[63:32]), lfsr2(tk2_in[31:0])};
         tk3_in = tk_perm(tk3_ff);
         tk3_in[63:0] = {lfsr3(tk3_in[63:32]), lfsr3(tk3_in[31:0])};
         rc_in = rc_next(rc_ff);
      end else if (cmd.round) begin
         if (!dec_ff) begin
            s0 = sb_fwd(st_ff[31:0]) ^ k0;
            s1 = sb_fwd(st_ff[63:32]) ^ k1;
            s2 = sb_fwd(st_ff[95:64]) ^ 32'h2;
            s3 = sb_fwd(st_ff[127:96]);
            s1 = rotl(s1, 8); s2 = rotl(s2, 16); s3 = rotl(s3, 24);
            s1 = s1 ^ s2;
            s2 = s2 ^ s0;
            t  = s3 ^ s2;
            st_in = {s2, s1, s0, t};
            tk1_in = tk_perm(tk1_ff);
            tk2_in = tk_perm(tk2_ff);
            tk2_in[63:0] = {lfsr2(tk2_in[63:32]), lfsr2(tk2_in[31:0])};
            tk3_in = tk_perm(tk3_ff);
            tk3_in[63:0] = {lfsr3(tk3_in[63:32]), lfsr3(tk3_in[31:0])};
            rc_in = rc_next(rc_ff);
         end else begin
            // tweakeys hold this round's key on entry; step them back after
            s0 = st_ff[31:0]; s1 = st_ff[63:32]; s2 = st_ff[95:64]; s3 = st_ff[127:96];
            t = s3; s3 = s0; s0 = s1; s1 = s2;
            s3 = s3 ^ t;
            s2 = t ^ s0;
            s1 = s1 ^ s2;
            s1 = rotl(s1, 24); s2 = rotl(s2, 16); s3 = rotl(s3, 8);
            s0 = s0 ^ k0; s1 = s1 ^ k1; s2 = s2 ^ 32'h2;
            st_in = {sb_inv(s3), sb_inv(s2), sb_inv(s1), sb_inv(s0)};
            tk1_in = tk_perm_inv(tk1_ff);
            tk2_in = tk2_ff;
            tk2_in[63:0] = {lfsr2_inv(tk2_ff[63:32]), lfsr2_inv(tk2_ff[31:0])};
            tk2_in = tk_perm_inv(tk2_in);
            tk3_in = tk3_ff;
            tk3_in[63:0] = {lfsr3_inv(tk3_ff[63:32]), lfsr3_inv(tk3_ff[31:0])};
            tk3_in = tk_perm_inv(tk3_in);
            rc_in = rc_prev(rc_ff);
         end
      end
   end

   // State, tweakey and per-request control registers
   always_ff @(posedge clock) begin
      st_ff <= st_in;
      rc_ff <= rc_in;
      if (cmd.load) begin
         dec_ff <= req_kind;
         tw_ff <= tweaked;
         tk1_ff <= tk1_in; tk2_ff <= tk2_in; tk3_ff <= tk3_in;
         if (tweaked) begin
            use2_ff <= 1'b1;
            use3_ff <= (words != 2'd1);
            rounds_ff <= (words != 2'd1) ? ROUND_W'(56) : ROUND_W'(48);
         end else begin
            use2_ff <= (words != 2'd1);
            use3_ff <= (words == 2'd3);
            rounds_ff <= (words == 2'd1) ? ROUND_W'(40) :
                         (words == 2'd2) ? ROUND_W'(48) : ROUND_W'(56);
         end
      end else if (cmd.fwd_key || cmd.round) begin
         tk1_ff <= tk1_in; tk2_ff <= tk2_in; tk3_ff <= tk3_in;
      end
   end

   // Decrypt starts from the tweakey of the last round, reached by the
   // forward run; each inverse round then steps the schedule back once.
   assign sts.rounds  = rounds_ff;
   assign sts.decrypt = dec_ff;
   assign rsp_result_lo = st_ff[63:0];
   assign rsp_result_hi = st_ff[127:64];

endmodule

### rtl/skc_ctrl.sv
// SKINNY-128 controller: sequences key run-forward, rounds and result strobe.
module skc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output logic                rsp_valid,
   output skc_pkg::dp_cmd_type cmd,
   input  skc_pkg::dp_sts_type sts
);
   import skc_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_KEYRUN, S_ROUND, S_DONE} state_type;

   state_type state_ff;
   logic [ROUND_W-1:0] cnt_ff;

   // Command decode
   always_comb begin
      cmd = '0;
      cmd.load = (state_ff == S_IDLE) && start;
      cmd.fwd_key = (state_ff == S_KEYRUN) && sts.decrypt;
      cmd.round = (state_ff == S_ROUND);
      cmd.done = (state_ff == S_DONE);
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = cmd.done;

   // State and round counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               cnt_ff <= '0;
               if (start) state_ff <= S_KEYRUN;
            end
            S_KEYRUN: begin
               // encrypt needs no run; decrypt steps forward rounds-1 times
               if (!sts.decrypt || cnt_ff == sts.rounds - ROUND_W'(2)) begin
                  state_ff <= S_ROUND;
                  cnt_ff <= '0;
               end else begin
                  cnt_ff <= cnt_ff + ROUND_W'(1);
               end
            end
            S_ROUND: begin
               if (cnt_ff == sts.rounds - ROUND_W'(1)) state_ff <= S_DONE;
               cnt_ff <= cnt_ff + ROUND_W'(1);
            end
            S_DONE: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.fwd_key, cmd.round, cmd.done})) else $error("cmd overlap");
   a_done_after_round: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_ROUND)) else $error("done without rounds");
   a_busy_no_load: assert property (@(posedge clock) disable iff (reset)
      busy |-> !cmd.load) else $error("load while busy");

endmodule

### rtl/skinny128_block_cipher.sv
// SKINNY-128 block cipher top level: configuration registers and module wiring.
//
// One request is taken when start is high and busy is low. Encryption needs no
// tweakey run; decryption first runs the tweakey schedule forward rounds-1
// steps to reach the last round key and then applies the inverse rounds. One
// round of the shared round unit runs per cycle. The result appears for a
// single cycle with rsp_valid and cannot be stalled; the next request can be
// taken in the cycle after it.
module skinny128_block_cipher (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_kind,
   input  logic [63:0]                   req_block_lo,
   input  logic [63:0]                   req_block_hi,
   input  logic [63:0]                   req_tweak_lo,
   input  logic [63:0]                   req_tweak_hi,
   output logic                          rsp_valid,
   output logic [63:0]                   rsp_result_lo,
   output logic [63:0]                   rsp_result_hi,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [skc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]                   csr_data
);
   import skc_pkg::*;

   logic [63:0] key_ff [6];
   logic [1:0]  key_words_ff;
   logic        tweaked_ff;
   dp_cmd_type  cmd;
   dp_sts_type  sts;

   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) key_ff[i] <= '0;
         key_words_ff <= 2'd1;
         tweaked_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_KEY0_LO: key_ff[0] <= csr_data;
            CSR_KEY0_HI: key_ff[1] <= csr_data;
            CSR_KEY1_LO: key_ff[2] <= csr_data;
            CSR_KEY1_HI: key_ff[3] <= csr_data;
            CSR_KEY2_LO: key_ff[4] <= csr_data;
            CSR_KEY2_HI: key_ff[5] <= csr_data;
            CSR_KEY_WORDS: key_words_ff <= csr_data[1:0];
            CSR_TWEAKED: tweaked_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   skc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .rsp_valid(rsp_valid), .cmd(cmd), .sts(sts)
   );

   skc_datapath u_dp (
      .clock(clock), .cmd(cmd), .sts(sts),
      .req_kind(req_kind), .req_block_lo(req_block_lo), .req_block_hi(req_block_hi),
      .req_tweak_lo(req_tweak_lo), .req_tweak_hi(req_tweak_hi),
      .key_words_in({key_ff[5], key_ff[4], key_ff[3], key_ff[2], key_ff[1], key_ff[0]}),
      .key_words(key_words_ff), .tweaked(tweaked_ff),
      .rsp_result_lo(rsp_result_lo), .rsp_result_hi(rsp_result_hi)
   );

endmodule
